@@ src/l2lb_pkg.sv @@
// Package for the L2 learning bridge: shared widths, defaults and types.
// Used by l2lb_cam and l2_learning_bridge; depends on nothing.

package l2lb_pkg;

    localparam int MAC_W             = 48;
    localparam int GROUP_BIT         = 40;
    localparam int IN_PORT_W         = 8;
    localparam int OUT_PORT_W        = 8;
    localparam int DEFAULT_ENTRIES   = 256;
    localparam int DEFAULT_PORT_BITS = 8;

    typedef struct packed {
        logic src_hit;
        logic dst_hit;
        logic room;
    } t_lookup;

endpackage

@@ src/l2lb_cam.sv @@
// Fully associative MAC-to-port table with parallel source and destination compare.
// Depends on l2lb_pkg; instantiated by l2_learning_bridge.

module l2lb_cam
    import l2lb_pkg::*;
#(
    parameter int ENTRIES   = DEFAULT_ENTRIES,
    parameter int PORT_BITS = DEFAULT_PORT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_learn_en,
    input  logic [MAC_W-1:0]     i_src_mac,
    input  logic [MAC_W-1:0]     i_dst_mac,
    input  logic [PORT_BITS-1:0] i_port,
    output t_lookup              o_status,
    output logic [PORT_BITS-1:0] o_dst_port
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [MAC_W-1:0]     r_mac  [ENTRIES];
    logic [PORT_BITS-1:0] r_port [ENTRIES];
    logic [CNT_W-1:0]     r_count;

    logic [ENTRIES-1:0]   w_valid;
    logic [ENTRIES-1:0]   w_src_match;
    logic [ENTRIES-1:0]   w_dst_match;
    logic [PORT_BITS-1:0] w_dst_port;
    logic                 w_src_hit;
    logic                 w_room;
    logic                 w_insert;

    always_comb begin
        w_dst_port = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid[i]     = CNT_W'(i) < r_count;
            w_src_match[i] = w_valid[i] && (r_mac[i] == i_src_mac);
            w_dst_match[i] = w_valid[i] && (r_mac[i] == i_dst_mac);
            w_dst_port     = w_dst_port | ({PORT_BITS{w_dst_match[i]}} & r_port[i]);
        end
    end

    assign w_src_hit  = |w_src_match;
    assign w_room     = r_count < CNT_W'(ENTRIES);
    assign w_insert   = i_learn_en && !w_src_hit && w_room;
    assign o_dst_port = w_dst_port;

    assign o_status.src_hit = w_src_hit;
    assign o_status.dst_hit = |w_dst_match;
    assign o_status.room    = w_room;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_learn_en && (w_src_match[i] || (w_insert && r_count == CNT_W'(i)))) begin
                r_mac[i]  <= i_src_mac;
                r_port[i] <= i_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_src_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_src_match))
        else $error("source MAC held in more than one entry");

    a_dst_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_dst_match))
        else $error("destination MAC held in more than one entry");

endmodule

@@ src/l2_learning_bridge.sv @@
// Pipeline: an accepted item is held in the input register, then moves to the result register,
// from which it is taken (input register, then result register).
// Throughput: one item per cycle, set by the parallel compare of source and
// destination against every table entry; a held result stalls the input once both are full.
// Reset clears the fill count, so the table is empty at once; no clearing pass runs.
// Depends on l2lb_pkg and l2lb_cam.

module l2_learning_bridge
    import l2lb_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_ENTRIES,
    parameter int PORT_BITS     = DEFAULT_PORT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MAC_W-1:0]      i_src_mac,
    input  logic [MAC_W-1:0]      i_dst_mac,
    input  logic [IN_PORT_W-1:0]  i_in_port,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_flood,
    output logic [OUT_PORT_W-1:0] o_egress_port
);

    logic                  r_s1_valid;
    logic [MAC_W-1:0]      r_s1_src;
    logic [MAC_W-1:0]      r_s1_dst;
    logic [IN_PORT_W-1:0]  r_s1_port;
    logic                  r_out_valid;
    logic                  r_out_flood;
    logic [OUT_PORT_W-1:0] r_egress_port;

    logic                  n_flood;
    logic [OUT_PORT_W-1:0] n_port;

    logic                            w_adv_out;
    logic                            w_adv_s1;
    logic                            w_move;
    logic                            w_src_uc;
    logic                            w_learn;
    logic [PORT_BITS+IN_PORT_W-1:0]  w_port_ext;
    logic [PORT_BITS-1:0]            w_stored_port;
    logic [PORT_BITS-1:0]            w_hit_port;
    logic [PORT_BITS+OUT_PORT_W-1:0] w_hit_ext;
    logic [PORT_BITS-1:0]            w_cam_port;
    t_lookup                         w_status;

    assign w_adv_out = !r_out_valid || !i_out_stall;
    assign w_adv_s1  = !r_s1_valid || w_adv_out;
    assign w_move    = r_s1_valid && w_adv_out;
    assign w_src_uc  = !r_s1_src[GROUP_BIT];
    assign w_learn   = w_move && w_src_uc;

    assign w_port_ext    = {{PORT_BITS{1'b0}}, r_s1_port};
    assign w_stored_port = w_port_ext[PORT_BITS-1:0];

    l2lb_cam #(
        .ENTRIES   (TABLE_ENTRIES),
        .PORT_BITS (PORT_BITS)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_learn_en (w_learn),
        .i_src_mac  (r_s1_src),
        .i_dst_mac  (r_s1_dst),
        .i_port     (w_stored_port),
        .o_status   (w_status),
        .o_dst_port (w_cam_port)
    );

    always_comb begin
        n_flood    = 1'b1;
        w_hit_port = '0;
        if (!r_s1_dst[GROUP_BIT]) begin
            if (w_src_uc && (r_s1_dst == r_s1_src) && (w_status.src_hit || w_status.room)) begin
                n_flood    = 1'b0;
                w_hit_port = w_stored_port;
            end else if (w_status.dst_hit) begin
                n_flood    = 1'b0;
                w_hit_port = w_cam_port;
            end
        end
    end

    assign w_hit_ext = {{OUT_PORT_W{1'b0}}, w_hit_port};
    assign n_port    = w_hit_ext[OUT_PORT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_s1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_s1 && i_in_valid) begin
            r_s1_src  <= i_src_mac;
            r_s1_dst  <= i_dst_mac;
            r_s1_port <= i_in_port;
        end
        if (w_move) begin
            r_out_flood   <= n_flood;
            r_egress_port <= n_port;
        end
    end

    assign o_in_stall    = !w_adv_s1;
    assign o_out_valid   = r_out_valid;
    assign o_flood       = r_out_flood;
    assign o_egress_port = r_egress_port;

    a_flood_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_flood) |-> (r_egress_port == '0))
        else $error("flooded item carries a nonzero port");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=>
            (r_out_valid && $stable(r_out_flood) && $stable(r_egress_port)))
        else $error("stalled result changed");

    a_in_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule

@@ tb/l2_learning_bridge_tb.sv @@
// Testbench for l2_learning_bridge: learns source MACs, forwards or floods each frame.
// Predicts every result from its own copy of the MAC table and checks each one in order.
// Depends on l2lb_pkg and the l2_learning_bridge RTL.
`timescale 1ns / 1ps

module l2_learning_bridge_tb;
    import l2lb_pkg::*;

    localparam int TABLE_SIZE  = DEFAULT_ENTRIES;
    localparam int LONG_HOLD   = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                  flood;
        logic [OUT_PORT_W-1:0] port;
    } t_fwd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [MAC_W-1:0]      i_src_mac;
    logic [MAC_W-1:0]      i_dst_mac;
    logic [IN_PORT_W-1:0]  i_in_port;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_flood;
    logic [OUT_PORT_W-1:0] o_egress_port;

    bit                    tbl_valid [TABLE_SIZE];
    logic [MAC_W-1:0]      tbl_mac   [TABLE_SIZE];
    logic [OUT_PORT_W-1:0] tbl_port  [TABLE_SIZE];

    t_fwd                  expected_fwd[$];
    logic [MAC_W-1:0]      mac_pool[$];
    int                    errors = 0;
    int                    cycle_count = 0;
    bit                    idle_en;
    bit                    hold_req;

    l2_learning_bridge uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_src_mac     (i_src_mac),
        .i_dst_mac     (i_dst_mac),
        .i_in_port     (i_in_port),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_flood       (o_flood),
        .o_egress_port (o_egress_port)
    );

    always #5 i_clk = ~i_clk;

    function automatic int find_mac(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        end
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (!tbl_valid[i]) return i;
        end
        return -1;
    endfunction

    function automatic int table_fill();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_SIZE; i++) n += tbl_valid[i];
        return n;
    endfunction

    function automatic t_fwd learn_and_forward(input logic [MAC_W-1:0] src,
                                               input logic [MAC_W-1:0] dst,
                                               input logic [IN_PORT_W-1:0] port);
        int   slot;
        t_fwd res;
        if (!src[GROUP_BIT]) begin
            slot = find_mac(src);
            if (slot < 0) slot = find_free();
            if (slot >= 0) begin
                tbl_valid[slot] = 1'b1;
                tbl_mac[slot]   = src;
                tbl_port[slot]  = OUT_PORT_W'(port);
            end
        end
        res.flood = 1'b1;
        res.port  = '0;
        if (!dst[GROUP_BIT]) begin
            slot = find_mac(dst);
            if (slot >= 0) begin
                res.flood = 1'b0;
                res.port  = tbl_port[slot];
            end
        end
        return res;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [MAC_W-1:0] m;
        m[47:32] = 16'($urandom_range(0, 65535));
        m[31:0]  = $urandom();
        return m;
    endfunction

    function automatic logic [MAC_W-1:0] unicast_mac();
        logic [MAC_W-1:0] m;
        m = random_mac();
        m[GROUP_BIT] = 1'b0;
        return m;
    endfunction

    function automatic logic [MAC_W-1:0] group_mac();
        logic [MAC_W-1:0] m;
        m = random_mac();
        m[GROUP_BIT] = 1'b1;
        return m;
    endfunction

    function automatic logic [MAC_W-1:0] pick_pool();
        return mac_pool[$urandom_range(0, mac_pool.size() - 1)];
    endfunction

    function automatic logic [IN_PORT_W-1:0] random_port();
        return IN_PORT_W'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                              input logic [IN_PORT_W-1:0] port);
        bit taken;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_src_mac  <= src;
        i_dst_mac  <= dst;
        i_in_port  <= port;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            if (taken) expected_fwd.push_back(learn_and_forward(src, dst, port));
            @(posedge i_clk);
        end
    endtask

    task automatic compare_result();
        t_fwd want;
        if (expected_fwd.size() == 0) begin
            $display("%0t: unexpected result flood %0b port %0d", $time, o_flood, o_egress_port);
            errors++;
        end else begin
            want = expected_fwd.pop_front();
            if (o_flood !== want.flood) begin
                $display("%0t: flood expected %0b actual %0b", $time, want.flood, o_flood);
                errors++;
            end
            if (o_egress_port !== want.port) begin
                $display("%0t: egress port expected %0d actual %0d", $time, want.port,
                         o_egress_port);
                errors++;
            end
        end
    endtask

    task automatic test_directed();
        logic [MAC_W-1:0] mac_a;
        mac_a = 48'h0200_0000_0001;
        send_frame(mac_a, 48'h0000_0000_0002, 8'd3);
        send_frame(48'h0000_0000_0000, mac_a, 8'd255);
        send_frame(48'h0000_0000_0000, 48'h0000_0000_0000, 8'd0);
        send_frame(48'hFEFF_FFFF_FFFF, 48'hFEFF_FFFF_FFFF, 8'd255);
        send_frame(mac_a, 48'hFFFF_FFFF_FFFF, 8'd17);
        send_frame(48'hFFFF_FFFF_FFFF, mac_a, 8'd9);
        send_frame(48'h0100_0000_00AA, 48'h0000_0000_00AA, 8'd5);
        send_frame(48'h0100_0000_00AA, 48'h0100_0000_00AA, 8'd5);
        send_frame(48'h0000_0000_00AA, 48'h0300_0000_0001, 8'd6);
        send_frame(48'h0000_0000_0002, mac_a, 8'd200);
        send_frame(mac_a, mac_a, 8'd200);
        send_frame(48'h0000_0000_0002, 48'h0000_0000_0002, 8'd1);
        send_frame(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 8'hAA);
        send_frame(48'h5455_5555_5555, 48'hAAAA_AAAA_AAAA, 8'h55);
        send_frame(48'hFEFF_FFFF_FFFF, 48'h0000_0000_0000, 8'h80);
    endtask

    task automatic test_random_traffic();
        logic [MAC_W-1:0] src;
        logic [MAC_W-1:0] dst;
        int               kind;
        for (int i = 0; i < 48; i++) mac_pool.push_back(unicast_mac());
        for (int n = 0; n < 480; n++) begin
            kind = $urandom_range(0, 9);
            src  = pick_pool();
            dst  = pick_pool();
            if (kind == 8) begin
                dst = group_mac();
            end else if (kind == 9) begin
                src = random_mac();
                dst = random_mac();
            end
            send_frame(src, dst, random_port());
        end
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (40) send_frame(pick_pool(), pick_pool(), random_port());
    endtask

    task automatic test_table_full();
        logic [MAC_W-1:0] fresh;
        logic [MAC_W-1:0] last;
        last = pick_pool();
        while (table_fill() < TABLE_SIZE) begin
            fresh = unicast_mac();
            send_frame(fresh, last, random_port());
            last = fresh;
        end
        repeat (40) begin
            fresh = unicast_mac();
            send_frame(fresh, fresh, random_port());
        end
        repeat (100) begin
            send_frame(pick_pool(), $urandom_range(0, 1) ? pick_pool() : last, random_port());
        end
    endtask

    task automatic test_steady_stream();
        logic [MAC_W-1:0] dst;
        idle_en = 1'b0;
        repeat (300) begin
            case ($urandom_range(0, 5))
                0:       dst = group_mac();
                1:       dst = random_mac();
                default: dst = pick_pool();
            endcase
            send_frame($urandom_range(0, 4) == 0 ? random_mac() : pick_pool(), dst,
                       random_port());
        end
    endtask

    initial begin
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) compare_result();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_src_mac   = '0;
        i_dst_mac   = '0;
        i_in_port   = '0;
        idle_en     = 1'b1;
        hold_req    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_output_backpressure();
        test_table_full();
        test_steady_stream();

        i_in_valid <= 1'b0;
        while (expected_fwd.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/l2lb_pkg.sv
src/l2lb_cam.sv
src/l2_learning_bridge.sv
tb/l2_learning_bridge_tb.sv
